>>> rtl/core/mfs_pkg.sv
// Shared types, codes and defaults for the maximum-frequency stack.
package mfs_pkg;

  // Default number of stack slots
  localparam int DEPTH_DEF = 64;

  // Width of a stored value
  localparam int DATA_W = 32;

  // Operation codes carried on in_tuser
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Result status codes carried on out_tuser
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;      // capture the input transaction, clear the scan state
    logic issue;       // issue a slot read at the scan pointer and advance it
    logic shift_start; // move the scan pointer to one above the chosen slot
    logic shift_mode;  // returning read data is moved down by one slot
    logic push_write;  // write the pushed value and its rank on top
    logic finish;      // load the result register and update the fill count
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_pop;   // the held operation is a pop
    logic err;      // pop on empty or push on full
    logic more;     // the scan pointer is still below the fill count
    logic pending;  // a slot read is in flight
    logic out_busy; // the result register holds an untaken result
  } sts_t;

endpackage

>>> rtl/core/mfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/core/mfs_ctrl.sv
// Controller state machine sequencing the slot scans of the stack.
module mfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfs_pkg::sts_t sts,
  output mfs_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PUSHW = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.err) begin
          state_nxt = S_DONE;
        end else if (sts.more) begin
          cmd.issue = 1'b1;
        end else if (!sts.pending) begin
          if (sts.op_pop) begin
            cmd.shift_start = 1'b1;
            state_nxt       = S_SHIFT;
          end else begin
            state_nxt = S_PUSHW;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift_mode = 1'b1;
        cmd.issue      = sts.more;
        if (!sts.more && !sts.pending) begin
          state_nxt = S_DONE;
        end
      end
      S_PUSHW: begin
        cmd.push_write = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/mfs_dp.sv
// Datapath: slot memory, scan pointer, rank counting, best-slot search, result.
module mfs_dp #(
  parameter int DEPTH = mfs_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_func,
  input  logic [mfs_pkg::DATA_W-1:0] in_value,
  input  mfs_pkg::cmd_t              cmd,
  output mfs_pkg::sts_t              sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mfs_pkg::DATA_W-1:0] out_value,
  output logic [1:0]                 out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int RW = $clog2(DEPTH + 1);
  localparam int DW = mfs_pkg::DATA_W;
  localparam int MW = DW + RW;

  logic          op_r;
  logic [DW-1:0] val_r;
  logic [RW-1:0] fill_r;
  logic [RW-1:0] idx_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic [RW-1:0] cnt_r;
  logic [RW-1:0] best_rank_r;
  logic [AW-1:0] best_idx_r;
  logic [DW-1:0] best_val_r;
  logic          out_valid_r;
  logic [DW-1:0] out_value_r;
  logic [1:0]    out_status_r;

  logic          err;
  logic          we;
  logic [AW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic [MW-1:0] rdata;
  logic [DW-1:0] rd_val;
  logic [RW-1:0] rd_rank;

  assign rd_val  = rdata[DW-1:0];
  assign rd_rank = rdata[MW-1:DW];

  // Flag pop on empty and push on full
  assign err = op_r ? (fill_r == '0) : (fill_r == RW'(DEPTH));

  assign sts.op_pop   = op_r;
  assign sts.err      = err;
  assign sts.more     = (idx_r < fill_r);
  assign sts.pending  = rd_vld_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  // Select the write: new top entry on push, one slot down on shift
  always_comb begin
    we    = 1'b0;
    waddr = rd_idx_r - AW'(1);
    wdata = rdata;
    if (cmd.push_write) begin
      we    = 1'b1;
      waddr = fill_r[AW-1:0];
      wdata = {cnt_r + RW'(1), val_r};
    end else if (rd_vld_r && cmd.shift_mode) begin
      we = 1'b1;
    end
  end

  mfs_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // Hold the operation
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_func;
      val_r <= in_value;
    end
  end

  // Advance the scan pointer and track reads in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.accept) begin
        idx_r <= '0;
      end else if (cmd.shift_start) begin
        idx_r <= RW'(best_idx_r) + RW'(1);
      end else if (cmd.issue) begin
        idx_r <= idx_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r[AW-1:0];
  end

  // Count copies and keep the topmost slot of highest rank
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt_r       <= '0;
      best_rank_r <= '0;
    end else if (rd_vld_r && !cmd.shift_mode) begin
      if (rd_val == val_r) begin
        cnt_r <= cnt_r + RW'(1);
      end
      if (rd_rank >= best_rank_r) begin
        best_rank_r <= rd_rank;
        best_idx_r  <= rd_idx_r;
        best_val_r  <= rd_val;
      end
    end
  end

  // Update the fill count and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (!err) begin
          fill_r <= op_r ? fill_r - RW'(1) : fill_r + RW'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_r <= (op_r && !err) ? best_val_r : '0;
      if (!err) begin
        out_status_r <= mfs_pkg::ST_DONE;
      end else if (op_r) begin
        out_status_r <= mfs_pkg::ST_EMPTY;
      end else begin
        out_status_r <= mfs_pkg::ST_FULL;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

>>> rtl/core/max_frequency_stack_core.sv
// Top level of the maximum-frequency stack.
//
// Input channel (in_*): one transaction per stack command. in_tuser selects
// the operation (push or pop), in_tdata carries the value to push.
// Result channel (out_*): exactly one transaction per command. out_tdata is
// the popped value (zero unless a pop succeeded), out_tuser the status:
// done, pop on empty stack, or push dropped because the stack is full.
// Commands are handled one at a time. The slots live in one RAM with a
// single read and a single write port; every command that is not refused
// scans the filled slots one per cycle, then a push writes its value on
// top and a pop moves each slot above the chosen one down by one. The next
// command is taken the cycle after the result is loaded. An error result
// is loaded without a scan.
// The result register lets the next command be taken while a result waits;
// while out_tready is low the block stalls before loading a further result.
// Reset empties the stack and clears the result valid flag; slot contents
// are left as they are and never used above the fill count.
module max_frequency_stack_core #(
  parameter int DEPTH = mfs_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] popped_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  mfs_pkg::cmd_t cmd;
  mfs_pkg::sts_t sts;

  mfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_tuser[0]),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata),
    .out_status (out_tuser)
  );

  // One command in flight: no new transaction straight after acceptance
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while another is in progress");

  // Only defined status codes leave the block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == mfs_pkg::ST_DONE || out_tuser == mfs_pkg::ST_EMPTY ||
                    out_tuser == mfs_pkg::ST_FULL))
    else $error("undefined status code");

  // Error results carry a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != mfs_pkg::ST_DONE |-> out_tdata == '0)
    else $error("error result with non-zero value");

  // Never write the top entry and shift in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push_write && cmd.shift_mode))
    else $error("push write during shift");

endmodule
